// ===== rtl/rbe_pkg.sv =====
package rbe_pkg;

   // pattern store geometry
   localparam int PATTERN_DEPTH = 512;
   localparam int ADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);

   // repeat count
   localparam int COUNT_W = 10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd999;

   // stream characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_OPEN = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // request modes
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DROPPED = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   // one request as held in the input register
   typedef struct packed {
      logic       mode;
      logic [7:0] in_byte;
   } req_item_type;

endpackage

// ===== rtl/rbe_input_stage.sv =====
module rbe_input_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [7:0]           req_in_byte,
   input  logic                 core_ready,
   output logic                 item_valid,
   output rbe_pkg::req_item_type item
);
   import rbe_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         take;
   logic         accept;

   // the core consumes the held request when its result slot is free
   assign take = valid_ff && core_ready;
   assign req_stall = valid_ff && !core_ready;
   assign accept = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.mode <= req_mode;
         item_ff.in_byte <= req_in_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// ===== rtl/rbe_decode_core.sv =====
module rbe_decode_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  rbe_pkg::req_item_type item,
   output logic                 core_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic [1:0]           rsp_kind,
   output logic                 rsp_last_of_run
);
   import rbe_pkg::*;

   typedef enum logic [2:0] {
      PH_START,
      PH_LIT,
      PH_COUNT,
      PH_PATTERN,
      PH_EXPAND
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [ADDR_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [COUNT_W-1:0] done_ff, done_in;

   logic               res_valid_ff, res_valid_in;
   logic [7:0]         res_byte_ff, res_byte_in;
   logic [1:0]         res_kind_ff, res_kind_in;
   logic               res_last_ff, res_last_in;
   logic               res_mem_ff, res_mem_in;

   logic [7:0]         pattern_mem [PATTERN_DEPTH];
   logic [7:0]         rd_data_ff;
   logic               wr_en;
   logic               rd_en;

   logic               take;
   logic [7:0]         b;
   logic               is_digit;
   logic [3:0]         digit_diff;
   logic [13:0]        count_prod;
   logic [COUNT_W-1:0] count_next;
   logic [LEN_W:0]     pos_inc;
   logic [COUNT_W:0]   done_inc;

   assign core_ready = !res_valid_ff || !rsp_stall;
   assign take = item_valid && core_ready;
   assign b = item.in_byte;

   // count digit accumulation with saturation
   assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
   assign digit_diff = 4'(b - CH_ZERO);
   always_comb begin
      logic [COUNT_W-1:0] base;
      base = (phase_ff == PH_COUNT) ? total_ff : '0;
      count_prod = {1'b0, base, 3'b000} + {3'b000, base, 1'b0} + {10'd0, digit_diff};
      count_next = (count_prod > {4'd0, COUNT_MAX}) ? COUNT_MAX : count_prod[COUNT_W-1:0];
   end

   assign pos_inc = {{(LEN_W + 1 - ADDR_W){1'b0}}, rd_pos_ff} + 1'b1;
   assign done_inc = {1'b0, done_ff} + 1'b1;

   // parse and expand for the held request
   always_comb begin
      phase_in = phase_ff;
      total_in = total_ff;
      len_in = len_ff;
      rd_pos_in = rd_pos_ff;
      done_in = done_ff;
      res_valid_in = 1'b0;
      res_byte_in = 8'd0;
      res_kind_in = KIND_DATA;
      res_last_in = 1'b0;
      res_mem_in = 1'b0;
      wr_en = 1'b0;
      rd_en = 1'b0;

      if (item.mode == MODE_DRAIN) begin
         if (phase_ff == PH_EXPAND && len_ff != '0
             && {{(LEN_W - ADDR_W){1'b0}}, rd_pos_ff} < len_ff) begin
            rd_en = 1'b1;
            res_valid_in = 1'b1;
            res_mem_in = 1'b1;
            rd_pos_in = pos_inc[ADDR_W-1:0];
            if (pos_inc >= {1'b0, len_ff}) begin
               rd_pos_in = '0;
               done_in = done_inc[COUNT_W-1:0];
               if (done_inc >= {1'b0, total_ff}) begin
                  res_last_in = 1'b1;
                  phase_in = PH_LIT;
                  total_in = '0;
                  done_in = '0;
               end
            end
         end
      end else begin
         unique case (phase_ff)
            PH_START, PH_COUNT: begin
               if (is_digit) begin
                  phase_in = PH_COUNT;
                  total_in = count_next;
               end else if (phase_ff == PH_COUNT && b == CH_SPACE) begin
                  total_in = '0;
               end else if (phase_ff == PH_COUNT && b == CH_OPEN) begin
                  phase_in = PH_PATTERN;
                  len_in = '0;
               end else if (phase_ff == PH_START && b == CH_SPACE) begin
                  phase_in = PH_COUNT;
                  total_in = '0;
               end else begin
                  phase_in = PH_LIT;
                  total_in = (phase_ff == PH_COUNT) ? '0 : total_ff;
                  res_valid_in = 1'b1;
                  res_byte_in = b;
               end
            end
            PH_PATTERN: begin
               if (b == CH_CLOSE) begin
                  if (len_ff == '0 || total_ff == '0) begin
                     phase_in = PH_LIT;
                     total_in = '0;
                  end else begin
                     phase_in = PH_EXPAND;
                     rd_pos_in = '0;
                     done_in = '0;
                  end
               end else if (len_ff >= LEN_W'(PATTERN_DEPTH)) begin
                  res_valid_in = 1'b1;
                  res_kind_in = KIND_OVERFLOW;
               end else begin
                  wr_en = 1'b1;
                  len_in = len_ff + 1'b1;
               end
            end
            PH_EXPAND: begin
               res_valid_in = 1'b1;
               res_kind_in = KIND_DROPPED;
            end
            default: begin
               // literal phase: a space opens a count, anything else passes
               phase_in = PH_LIT;
               if (b == CH_SPACE) begin
                  phase_in = PH_COUNT;
                  total_in = '0;
               end else begin
                  res_valid_in = 1'b1;
                  res_byte_in = b;
               end
            end
         endcase
      end
   end

   // parse state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         total_ff <= '0;
         len_ff <= '0;
         rd_pos_ff <= '0;
         done_ff <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
            total_ff <= total_in;
            len_ff <= len_in;
            rd_pos_ff <= rd_pos_in;
            done_ff <= done_in;
            res_valid_ff <= res_valid_in;
            res_byte_ff <= res_byte_in;
            res_kind_ff <= res_kind_in;
            res_last_ff <= res_last_in;
            res_mem_ff <= res_mem_in;
         end else if (core_ready) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   // pattern store, read data registered alongside the result
   always_ff @(posedge clock) begin
      if (take && wr_en) begin
         pattern_mem[len_ff[ADDR_W-1:0]] <= b;
      end
      if (take && rd_en) begin
         rd_data_ff <= pattern_mem[rd_pos_ff];
      end
   end

   assign rsp_valid = res_valid_ff;
   assign rsp_out_byte = res_mem_ff ? rd_data_ff : res_byte_ff;
   assign rsp_kind = res_kind_ff;
   assign rsp_last_of_run = res_last_ff;

endmodule

// ===== rtl/repeat_block_expander.sv =====
// repeat_block_expander
// Expands a compressed byte stream of literals and ' N[pattern]' blocks.
// Request channel (req_valid / req_stall): req_mode 0 carries a stream byte
// in req_in_byte, req_mode 1 is a drain tick asking for the next expanded
// byte. Response channel (rsp_valid / rsp_stall): rsp_out_byte, rsp_kind
// (data, dropped during expansion, pattern overflow) and rsp_last_of_run.
// A request causes zero or one response; outside an expansion, spaces,
// count digits, brackets, stored pattern bytes and idle drain ticks give none.
// A response is registered: its request passes the input register, then the
// result register with the pattern store read. Throughput: one request per
// cycle while the receiver does not stall; every request is handled in a
// single pass against a 512 byte pattern store with one write and one read
// port. When the receiver stalls, the response holds and the block keeps the
// request in its input register, then raises req_stall until the result
// slot frees up.
// Reset (synchronous, active high) returns the parser to the start of a
// stream and empties both registers; the pattern store is not cleared, as
// only bytes written for the current pattern are ever read.
module repeat_block_expander (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_last_of_run
);
   import rbe_pkg::*;

   logic         item_valid;
   req_item_type item;
   logic         core_ready;

   rbe_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_in_byte (req_in_byte),
      .core_ready  (core_ready),
      .item_valid  (item_valid),
      .item        (item)
   );

   rbe_decode_core u_decode_core (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .core_ready      (core_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_kind        (rsp_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== rtl/rbe_checker.sv =====
module rbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_kind,
   input logic       rsp_last_of_run
);
   import rbe_pkg::*;

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // request side only backs up behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stall without stalled response");

   // only defined kinds leave the block
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_DATA || rsp_kind == KIND_DROPPED
                     || rsp_kind == KIND_OVERFLOW))
      else $error("undefined response kind");

   // flag responses carry no byte and never end a run
   a_flag_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_DATA) |-> (rsp_out_byte == 8'd0 && !rsp_last_of_run))
      else $error("flag response with data or end of run");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte)
                                    && $stable(rsp_kind) && $stable(rsp_last_of_run)))
      else $error("stalled response changed");

endmodule

bind repeat_block_expander rbe_checker u_rbe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_kind        (rsp_kind),
   .rsp_last_of_run (rsp_last_of_run)
);
